/* rtl/hd_pkg.sv */
package hd_pkg;

  // Field widths.
  localparam int LAT_W     = 24;
  localparam int LON_W     = 25;
  localparam int RAD_W     = 22;
  localparam int DIST_W    = 24;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;

  // Internal widths.
  localparam int ANG_W       = 27;  // angle differences in degrees * 65536
  localparam int COS_W       = 34;  // signed Q30 cosine and rotation vector
  localparam int Z_W         = 33;  // signed Q30 phase
  localparam int Q30_W       = 31;  // unsigned Q30 value in [0, 1]
  localparam int ISQ_W       = 62;  // square root remainder and partial root
  localparam int ISQRT_STEPS = 31;  // one result bit per stage
  localparam int VEC_W       = 35;  // vectoring CORDIC x and y

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REF_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd2;

  // Register reset values.
  localparam logic signed [LAT_W-1:0] REF_LAT_RST = 24'sd2198825;
  localparam logic signed [LON_W-1:0] REF_LON_RST = -25'sd7711136;
  localparam logic [RAD_W-1:0]        RADIUS_RST  = 22'd1013453;

  // Angles in degrees * 65536.
  localparam logic [24:0] DEG90  = 25'd5898240;
  localparam logic [24:0] DEG180 = 25'd11796480;
  localparam logic [24:0] DEG360 = 25'd23592960;

  // Degrees * 65536 to Q30 radians, pi/180 in Q44, split for two narrow products.
  localparam logic [38:0] DEG_TO_RAD_Q44 = 39'd307041569098;
  localparam logic [18:0] D2R_HI = DEG_TO_RAD_Q44[38:20];
  localparam logic [19:0] D2R_LO = DEG_TO_RAD_Q44[19:0];

  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [COS_W-1:0] cos_t;
  typedef logic signed [Z_W-1:0]   phase_t;

  localparam cos_t CORDIC_GAIN = 34'sd652032874;

  // Arctangent of 2^-i in Q30 radians.
  function automatic phase_t atan_q30(input int i);
    phase_t r;
    r = '0;
    case (i)
      0: r = 33'sd843314857;
      1: r = 33'sd497837829;
      2: r = 33'sd263043837;
      3: r = 33'sd133525159;
      4: r = 33'sd67021687;
      5: r = 33'sd33543516;
      6: r = 33'sd16775851;
      7: r = 33'sd8388437;
      8: r = 33'sd4194283;
      9: r = 33'sd2097149;
      default: begin
        if (i <= 30) begin
          r = phase_t'(1) << (30 - i);
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/hd_cos.sv */
module hd_cos #(
  parameter int STEPS = 24
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  hd_pkg::ang_t  angle_i,
  output hd_pkg::cos_t  cos_o
);
  import hd_pkg::*;

  localparam ang_t DEG360_S = ang_t'(DEG360);

  logic [24:0] mod_d, mod_q;
  logic [24:0] fold_d;
  logic [22:0] fold_q;
  logic        neg_d, neg1_q, neg2_q;
  logic [41:0] pp_hi_q;
  logic [42:0] pp_lo_q;
  logic [62:0] rad_sum;
  cos_t        x_q [STEPS+1];
  cos_t        y_q [STEPS+1];
  phase_t      z_q [STEPS+1];
  logic        sg_q [STEPS+1];
  cos_t        cos_q;

  // Bring the angle into one turn.
  always_comb begin
    ang_t m;
    m = angle_i;
    if (m < 0) begin
      m = m + DEG360_S;
    end
    if (m < 0) begin
      m = m + DEG360_S;
    end
    if (m >= DEG360_S) begin
      m = m - DEG360_S;
    end
    mod_d = m[24:0];
  end

  // Fold into the first quadrant and note the sign of the cosine.
  always_comb begin
    fold_d = mod_q;
    if (fold_d > DEG180) begin
      fold_d = DEG360 - fold_d;
    end
    neg_d = fold_d > DEG90;
    if (neg_d) begin
      fold_d = DEG180 - fold_d;
    end
  end

  // Radians conversion as two registered partial products, summed into the first CORDIC phase.
  assign rad_sum = {pp_hi_q, 20'b0} + 63'(pp_lo_q) + (63'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mod_q   <= mod_d;
      fold_q  <= fold_d[22:0];
      neg1_q  <= neg_d;
      pp_hi_q <= fold_q * D2R_HI;
      pp_lo_q <= fold_q * D2R_LO;
      neg2_q  <= neg1_q;
      x_q[0]  <= CORDIC_GAIN;
      y_q[0]  <= '0;
      z_q[0]  <= rad_sum[62:30];
      sg_q[0] <= neg2_q;
    end
  end

  // Rotation CORDIC, one micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam phase_t ATAN = atan_q30(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
        sg_q[i+1] <= sg_q[i];
      end
    end
  end

  // Restore the quadrant sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= sg_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    end
  end

  assign cos_o = cos_q;

endmodule

/* rtl/hd_isqrt.sv */
module hd_isqrt (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [hd_pkg::Q30_W-1:0] val_i,
  output logic [hd_pkg::Q30_W-1:0] root_o
);
  import hd_pkg::*;

  logic [ISQ_W-1:0] rem_in [ISQRT_STEPS];
  logic [ISQ_W-1:0] res_in [ISQRT_STEPS];
  logic [ISQ_W-1:0] rem_q  [ISQRT_STEPS];
  logic [ISQ_W-1:0] res_q  [ISQRT_STEPS];

  // Digit-by-digit floor square root of val * 2^30, one root bit per stage.
  for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_bit
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQRT_STEPS - 1 - j));
    logic [ISQ_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in[j] = {1'b0, val_i, 30'b0};
      assign res_in[j] = '0;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign res_in[j] = res_q[j-1];
    end

    assign trial = res_in[j] + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in[j] >= trial) begin
          rem_q[j] <= rem_in[j] - trial;
          res_q[j] <= (res_in[j] >> 1) + BIT;
        end else begin
          rem_q[j] <= rem_in[j];
          res_q[j] <= res_in[j] >> 1;
        end
      end
    end
  end

  assign root_o = res_q[ISQRT_STEPS-1][Q30_W-1:0];

endmodule

/* rtl/hd_atan.sv */
module hd_atan #(
  parameter int STEPS = 24
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [hd_pkg::Q30_W-1:0] x_i,
  input  logic [hd_pkg::Q30_W-1:0] y_i,
  output hd_pkg::phase_t           z_o
);
  import hd_pkg::*;

  typedef logic signed [VEC_W-1:0] vec_t;

  vec_t   x_in [STEPS];
  vec_t   y_in [STEPS];
  phase_t z_in [STEPS];
  vec_t   x_q  [STEPS];
  vec_t   y_q  [STEPS];
  phase_t z_q  [STEPS];

  // Vectoring CORDIC: drive y to zero and accumulate the angle.
  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    localparam phase_t ATAN = atan_q30(i);

    if (i == 0) begin : g_first
      assign x_in[i] = vec_t'({1'b0, x_i});
      assign y_in[i] = vec_t'({1'b0, y_i});
      assign z_in[i] = '0;
    end else begin : g_next
      assign x_in[i] = x_q[i-1];
      assign y_in[i] = y_q[i-1];
      assign z_in[i] = z_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_in[i] > 0) begin
          x_q[i] <= x_in[i] + (y_in[i] >>> i);
          y_q[i] <= y_in[i] - (x_in[i] >>> i);
          z_q[i] <= z_in[i] + ATAN;
        end else begin
          x_q[i] <= x_in[i] - (y_in[i] >>> i);
          y_q[i] <= y_in[i] + (x_in[i] >>> i);
          z_q[i] <= z_in[i] - ATAN;
        end
      end
    end
  end

  assign z_o = z_q[STEPS-1];

endmodule

/* rtl/haversine_distance.sv */
// Throughput: one item per cycle while not stalled, set by the fully pipelined
// CORDIC and square-root stages.
// The pipeline stalls only once the output register and its skid entry both hold items.
// Reset: rst_ni clears all valid bits and loads the default reference point and radius.
module haversine_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [hd_pkg::LAT_W-1:0]  target_latitude_i,
  input  logic signed [hd_pkg::LON_W-1:0]  target_longitude_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hd_pkg::DIST_W-1:0]        arc_distance_o
);
  import hd_pkg::*;

  localparam int COS_LAT   = CORDIC_STEPS + 5;
  localparam int MERGE_LAT = 7;
  localparam int PIPE_LAT  = 1 + COS_LAT + MERGE_LAT + ISQRT_STEPS + CORDIC_STEPS + 1;
  localparam int HAV_W     = 32;
  localparam int MAG_W     = 32;
  localparam int PM_W      = 34;
  localparam int QM_W      = 37;
  localparam int AS_W      = 39;

  // Configuration registers.
  logic signed [LAT_W-1:0] ref_lat_q;
  logic signed [LON_W-1:0] ref_lon_q;
  logic [RAD_W-1:0]        radius_q;

  // Pipeline control.
  logic                en;
  logic [PIPE_LAT-1:0] vld_q;
  logic                res_vld;

  // Input stage.
  ang_t dlat_q, dlon_q, lat1_q, lat2_q;
  cos_t c_dlat, c_dlon, c_lat1, c_lat2;

  // Combining stages.
  logic [HAV_W-1:0] m1_hlat_q, m1_hlon_q, m2_hlat_q, m2_hlon_q;
  logic [HAV_W-1:0] m3_hlat_q, m3_hlon_q, m4_hlat_q, m5_hlat_q;
  logic [MAG_W-1:0] m1_mag1_q, m1_mag2_q;
  logic             m1_sgn_q, m2_sgn_q, m3_sgn_q, m4_sgn_q, m5_sgn_q;
  logic [63:0]      m2_prod_q;
  logic [64:0]      pm_sum;
  logic [PM_W-1:0]  m3_pm_q;
  logic [65:0]      m4_q_q;
  logic [66:0]      qm_sum;
  logic [QM_W-1:0]  m5_qm_q;
  logic [Q30_W-1:0] a_d, m6_a_q, m7_a_q, m7_b_q;

  // Arc and distance.
  logic [Q30_W-1:0] root_x, root_y;
  phase_t           arc_z;
  logic [Q30_W-1:0] arc_zc;
  logic [52:0]      f1_prod_q;
  logic [53:0]      dist_sum;
  logic [DIST_W-1:0] dist_sat;

  // Output register and skid entry.
  logic              out_vld_q, skid_vld_q;
  logic [DIST_W-1:0] out_q, skid_q;

  function automatic logic [HAV_W-1:0] hav_of(input cos_t c);
    logic signed [COS_W:0] hv;
    hv = $signed({4'b0, Q30_ONE}) - {c[COS_W-1], c};
    return (hv < 0) ? '0 : hv[HAV_W:1];
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input cos_t c);
    cos_t m;
    m = c[COS_W-1] ? -c : c;
    return m[MAG_W-1:0];
  endfunction

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q <= REF_LAT_RST;
      ref_lon_q <= REF_LON_RST;
      radius_q  <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REF_LAT: ref_lat_q <= cfg_wdata_i[LAT_W-1:0];
        REG_REF_LON: ref_lon_q <= cfg_wdata_i[LON_W-1:0];
        REG_RADIUS:  radius_q  <= cfg_wdata_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves while the skid entry is free.
  assign en         = !skid_vld_q;
  assign in_ready_o = en;
  assign res_vld    = vld_q[PIPE_LAT-1] & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // Angle differences and the two latitudes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q <= ang_t'(target_latitude_i) - ang_t'(ref_lat_q);
      dlon_q <= ang_t'(target_longitude_i) - ang_t'(ref_lon_q);
      lat1_q <= ang_t'(ref_lat_q);
      lat2_q <= ang_t'(target_latitude_i);
    end
  end

  // Four cosines in lockstep.
  hd_cos #(.STEPS(CORDIC_STEPS)) u_cos_dlat (
    .clk_i(clk_i), .en_i(en), .angle_i(dlat_q), .cos_o(c_dlat));
  hd_cos #(.STEPS(CORDIC_STEPS)) u_cos_dlon (
    .clk_i(clk_i), .en_i(en), .angle_i(dlon_q), .cos_o(c_dlon));
  hd_cos #(.STEPS(CORDIC_STEPS)) u_cos_lat1 (
    .clk_i(clk_i), .en_i(en), .angle_i(lat1_q), .cos_o(c_lat1));
  hd_cos #(.STEPS(CORDIC_STEPS)) u_cos_lat2 (
    .clk_i(clk_i), .en_i(en), .angle_i(lat2_q), .cos_o(c_lat2));

  // Rounded products and the clamped haversine sum.
  assign pm_sum = {1'b0, m2_prod_q} + (65'd1 << 29);
  assign qm_sum = {1'b0, m4_q_q} + (67'd1 << 29);

  always_comb begin
    logic signed [AS_W-1:0] av;
    if (m5_sgn_q) begin
      av = $signed({7'b0, m5_hlat_q}) - $signed({2'b0, m5_qm_q});
    end else begin
      av = $signed({7'b0, m5_hlat_q}) + $signed({2'b0, m5_qm_q});
    end
    if (av < 0) begin
      a_d = '0;
    end else if (av > $signed({8'b0, Q30_ONE})) begin
      a_d = Q30_ONE;
    end else begin
      a_d = av[Q30_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_hlat_q <= hav_of(c_dlat);
      m1_hlon_q <= hav_of(c_dlon);
      m1_mag1_q <= mag_of(c_lat1);
      m1_mag2_q <= mag_of(c_lat2);
      m1_sgn_q  <= c_lat1[COS_W-1] ^ c_lat2[COS_W-1];

      m2_prod_q <= m1_mag1_q * m1_mag2_q;
      m2_hlat_q <= m1_hlat_q;
      m2_hlon_q <= m1_hlon_q;
      m2_sgn_q  <= m1_sgn_q;

      m3_pm_q   <= pm_sum[63:30];
      m3_hlat_q <= m2_hlat_q;
      m3_hlon_q <= m2_hlon_q;
      m3_sgn_q  <= m2_sgn_q;

      m4_q_q    <= m3_hlon_q * m3_pm_q;
      m4_hlat_q <= m3_hlat_q;
      m4_sgn_q  <= m3_sgn_q;

      m5_qm_q   <= qm_sum[66:30];
      m5_hlat_q <= m4_hlat_q;
      m5_sgn_q  <= m4_sgn_q;

      m6_a_q    <= a_d;

      m7_a_q    <= m6_a_q;
      m7_b_q    <= Q30_ONE - m6_a_q;
    end
  end

  // sqrt(1 - a) and sqrt(a), then the arc angle.
  hd_isqrt u_sqrt_x (.clk_i(clk_i), .en_i(en), .val_i(m7_b_q), .root_o(root_x));
  hd_isqrt u_sqrt_y (.clk_i(clk_i), .en_i(en), .val_i(m7_a_q), .root_o(root_y));

  hd_atan #(.STEPS(CORDIC_STEPS)) u_atan (
    .clk_i(clk_i), .en_i(en), .x_i(root_x), .y_i(root_y), .z_o(arc_z));

  // Scale by the radius; a negative arc counts as zero.
  assign arc_zc = arc_z[Z_W-1] ? '0 : arc_z[Q30_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_prod_q <= radius_q * arc_zc;
    end
  end

  // Round and saturate.
  assign dist_sum = {1'b0, f1_prod_q} + (54'd1 << 28);
  assign dist_sat = dist_sum[53] ? '1 : dist_sum[52:29];

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_ready_i) begin
        out_vld_q <= skid_vld_q | res_vld;
      end
      if (skid_vld_q) begin
        if (!out_vld_q || out_ready_i) begin
          skid_vld_q <= 1'b0;
        end
      end else if (res_vld && out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skid_vld_q ? skid_q : dist_sat;
    end
    if (!skid_vld_q && res_vld && out_vld_q && !out_ready_i) begin
      skid_q <= dist_sat;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign arc_distance_o = out_q;

endmodule

/* rtl/hd_chk.sv */
module hd_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hd_pkg::DIST_W-1:0]     arc_distance_o
);

  logic [7:0] pend_d, pend_q;

  // Items accepted and not yet delivered.
  always_comb begin
    pend_d = pend_q;
    if (in_valid_i && in_ready_o) begin
      pend_d = pend_d + 8'd1;
    end
    if (out_valid_o && out_ready_i) begin
      pend_d = pend_d - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(arc_distance_o))
    else $error("result changed while stalled");

  // Every delivered item belongs to an accepted one.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> pend_q != 8'd0)
    else $error("result delivered with no item pending");

  // Input is held off only behind a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && $past(out_valid_o && !out_ready_i))
    else $error("input refused without output backpressure");

endmodule

bind haversine_distance hd_chk u_hd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .arc_distance_o (arc_distance_o)
);

/* sim/tb_haversine_distance.sv */
`timescale 1ns / 100ps

module tb_haversine_distance;
  import hd_pkg::*;

  localparam int STEPS = 24;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 2 * STEPS + 60;
  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint ANG90 = 5898240;
  localparam longint ANG180 = 11796480;
  localparam longint ANG360 = 23592960;
  localparam longint unsigned RAD_PER_DEG_Q44 = 64'd307041569098;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint DIST_LIMIT = 16777215;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [LAT_W-1:0] target_latitude_i = '0;
  logic signed [LON_W-1:0] target_longitude_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DIST_W-1:0] arc_distance_o;

  // Shadow copy of the configuration registers.
  logic signed [LAT_W-1:0] ref_lat = REF_LAT_RST;
  logic signed [LON_W-1:0] ref_lon = REF_LON_RST;
  logic [RAD_W-1:0] radius = RADIUS_RST;

  logic [DIST_W-1:0] pending_distances[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  haversine_distance #(.CORDIC_STEPS(STEPS)) uut (.*);

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint arctan_q30(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  function automatic longint q30_product(longint a, longint b);
    bit neg;
    longint unsigned ma, mb;
    longint r;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r = longint'((ma * mb + (64'd1 << 29)) >> 30);
    return neg ? -r : r;
  endfunction

  // Cosine in Q30 of an angle in degrees * 65536, by rotation CORDIC.
  function automatic longint cosine_q30(longint deg);
    longint unsigned r;
    longint x, y, z, nx, ny;
    bit neg;
    r = longint'(deg + 4 * ANG360) % ANG360;
    if (r > ANG180) r = ANG360 - r;
    neg = r > ANG90;
    if (neg) r = ANG180 - r;
    z = longint'((r * RAD_PER_DEG_Q44 + (64'd1 << 29)) >> 30);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arctan_q30(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arctan_q30(i);
      end
      x = nx;
      y = ny;
    end
    return neg ? -x : x;
  endfunction

  function automatic longint haversine_q30(longint deg);
    longint v;
    v = ONE_Q30 - cosine_q30(deg);
    if (v < 0) v = 0;
    return v >>> 1;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Distance from the reference point to the target, in 1/256 mile.
  function automatic logic [DIST_W-1:0] predict_distance(logic signed [LAT_W-1:0] lat2,
                                                         logic signed [LON_W-1:0] lon2);
    longint lat1, lon1, a, x, y, z, nx, ny;
    longint unsigned d;
    lat1 = ref_lat;
    lon1 = ref_lon;
    a = haversine_q30(longint'(lat2) - lat1) +
        q30_product(haversine_q30(longint'(lon2) - lon1),
                    q30_product(cosine_q30(lat1), cosine_q30(longint'(lat2))));
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    x = longint'(floor_sqrt(longint'(ONE_Q30 - a) << 30));
    y = longint'(floor_sqrt(a << 30));
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arctan_q30(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arctan_q30(i);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    d = (longint'(radius) * z + (64'd1 << 28)) >> 29;
    if (d > DIST_LIMIT) d = DIST_LIMIT;
    return d[DIST_W-1:0];
  endfunction

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each delivered distance with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected distance %0d", $time, arc_distance_o);
        errors++;
      end else begin
        if (arc_distance_o !== pending_distances[0]) begin
          $display("%0t: arc_distance expected %0d actual %0d", $time,
                   pending_distances[0], arc_distance_o);
          errors++;
        end
        void'(pending_distances.pop_front());
      end
    end
  end

  // Offer one item, with random idle cycles first, and wait for acceptance.
  task automatic send_item(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    target_latitude_i <= lat;
    target_longitude_i <= lon;
    do @(posedge clk_i); while (!in_ready_o);
    pending_distances = {pending_distances, predict_distance(lat, lon)};
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_REF_LAT: ref_lat = value[LAT_W-1:0];
      REG_REF_LON: ref_lon = value[LON_W-1:0];
      REG_RADIUS:  radius = value[RAD_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [LAT_W-1:0] random_lat();
    if ($urandom_range(9) == 0) return LAT_W'($urandom);
    return LAT_W'(int'($urandom_range(2 * ANG90)) - int'(ANG90));
  endfunction

  function automatic logic signed [LON_W-1:0] random_lon();
    if ($urandom_range(9) == 0) return LON_W'($urandom);
    return LON_W'(int'($urandom_range(2 * ANG180)) - int'(ANG180));
  endfunction

  // Extremes of the fields, coincident and antipodal points, out-of-range angles.
  task automatic test_directed();
    send_item(ref_lat, ref_lon);
    send_item(24'sd5898240, 25'sd11796480);
    send_item(-24'sd5898240, -25'sd11796480);
    send_item(-ref_lat, ref_lon + 25'sd11796480);
    send_item(24'sh7FFFFF, 25'sh0FFFFFF);
    send_item(24'sh800000, 25'sh1000000);
    send_item('0, '0);
    send_item(24'sh7FFFFF, 25'sh1000000);
    send_item(24'sh800000, 25'sh0FFFFFF);
    send_item(24'sd5898240, ref_lon);
    send_item(24'sd1, -25'sd1);
    send_item(ref_lat + 24'sd1, ref_lon);
    wait_idle();
  endtask

  // Several register settings, extremes included, plus an ignored index.
  task automatic test_config_sweep();
    logic [CFG_W-1:0] lats[4] = '{25'd0, 25'h1A5_0000 & 25'hFFFFFF, 25'h0A5_0000, 25'h1234567};
    logic [CFG_W-1:0] lons[4] = '{25'h1000000, 25'h0B4_0000, 25'h0, 25'h1FFFFFF};
    logic [CFG_W-1:0] rads[4] = '{25'd0, 25'h3FFFFF, 25'h1FFFFFF, 25'd1013453};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_REF_LAT, lats[s]);
      write_reg(REG_REF_LON, lons[s]);
      write_reg(REG_RADIUS, rads[s]);
      write_reg(REG_UNUSED, CFG_W'($urandom));
      send_item(-ref_lat, ref_lon + 25'sd11796480);
      send_item(ref_lat, ref_lon);
      repeat (10) send_item(random_lat(), random_lon());
      wait_idle();
    end
    write_reg(REG_REF_LAT, 25'(REF_LAT_RST));
    write_reg(REG_REF_LON, 25'(REF_LON_RST));
    write_reg(REG_RADIUS, 25'(RADIUS_RST));
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_lat(), random_lon());
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver held off while items keep coming, so the input must stall.
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (110) send_item(random_lat(), random_lon());
    join
    wait_idle();
  endtask

  // Sender pauses until every result is back, then resumes.
  task automatic test_pause_resume();
    repeat (15) send_item(random_lat(), random_lon());
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (15) send_item(random_lat(), random_lon());
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_sweep();
    test_random(60, 0, 0);
    test_random(60, 79, 0);
    test_random(60, 0, 79);
    test_random(60, 17, 17);
    test_backpressure();
    test_pause_resume();
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
